FILE: sv/i2cmbw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbw_pkg: shared types and constants of the multilane i2c byte writer
// Request and phase item layouts, command codes and the fixed pin patterns
// of the start and stop conditions.
// ----------------------------------------------------------------------------
package i2cmbw_pkg;

    localparam int ACK_W = 9;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    // pin patterns of start and stop, bit i is phase i
    localparam logic [5:0] START_SCL = 6'b001111;
    localparam logic [5:0] START_SDA = 6'b100111;
    localparam logic [5:0] STOP_SCL  = 6'b111100;
    localparam logic [5:0] STOP_SDA  = 6'b100001;

    localparam logic [2:0] COND_LAST_IDX = 3'd5;
    localparam logic [2:0] BIT_LAST_SUB  = 3'd2;
    localparam logic [2:0] ACK_LAST_IDX  = 3'd3;
    localparam logic [2:0] BYTE_LAST_BIT = 3'd7;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [7:0]       data_byte;
        logic [ACK_W-1:0] ack_lines;
    } t_in_item;

    typedef struct packed {
        logic             scl_release;
        logic             sda_release;
        logic [ACK_W-1:0] sampled_ack;
        logic             last;
    } t_out_item;

endpackage

FILE: sv/i2c_multilane_byte_writer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_multilane_byte_writer_top: open-drain i2c master pin sequencer
// One clock pin and all data pins driven together, one pin phase per result.
// ----------------------------------------------------------------------------
// Usage:
//   request channel (i_in_valid / o_in_stall / i_in_item): one command per
//   request, start, write byte or stop. A request with an unknown command
//   is taken and dropped.
//   phase channel (o_out_valid / i_out_stall / o_out_item): one pin phase
//   per result, last set on the final phase of the command; a byte write
//   reports the masked acknowledge levels on its final phase.
//   A taken request is registered in the sequencer, and its phases then
//   pass through the output register. Phases leave one per cycle while
//   the receiver does not stall: 6 for start and stop, 28 for a byte.
//   The next request is taken at the edge that hands off the final phase
//   of the current one, so commands follow each other without a gap; the
//   phase and bit counters set how many phases each command has.
//   When the receiver stalls, the output register holds its phase and the
//   sequencer waits; the request side stalls only while a command runs.
//   Reset empties the output register and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module i2c_multilane_byte_writer_top
    import i2cmbw_pkg::*;
#(
    parameter int LANES = 9
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    localparam logic [ACK_W-1:0] LANE_MASK =
        (LANES >= ACK_W) ? {ACK_W{1'b1}} : ACK_W'((1 << LANES) - 1);

    t_in_item  w_in_masked;
    t_out_item w_phase;
    logic      w_phase_valid;
    logic      w_advance;

    logic      r_out_valid;
    t_out_item r_out_item;

    always_comb begin
        w_in_masked           = i_in_item;
        w_in_masked.ack_lines = i_in_item.ack_lines & LANE_MASK;
    end

    assign w_advance = w_phase_valid && (!r_out_valid || !i_out_stall);

    i2cmbw_sequencer u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_in_item     (w_in_masked),
        .o_phase_valid (w_phase_valid),
        .o_phase       (w_phase),
        .i_advance     (w_advance)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
            r_out_item  <= w_phase;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: sv/i2cmbw_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cmbw_sequencer: pin phase sequencer
// Steps through the phases of one command, shifting the byte out one bit
// per three phases, and offers the current phase until it is taken.
// ----------------------------------------------------------------------------
module i2cmbw_sequencer
    import i2cmbw_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_phase_valid,
    output t_out_item o_phase,
    input  logic      i_advance
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_STOP,
        S_BITS,
        S_ACK
    } t_state;

    t_state           r_state;
    logic [2:0]       r_cnt;
    logic [2:0]       r_bitn;
    logic [7:0]       r_shift;
    logic             r_sda_prev;
    logic [ACK_W-1:0] r_ack;

    logic w_accept;
    logic w_done;

    assign o_phase_valid = (r_state != S_IDLE);
    assign w_done        = o_phase_valid && i_advance && o_phase.last;
    assign o_in_stall    = o_phase_valid && !w_done;
    assign w_accept      = i_in_valid && !o_in_stall;

    always_comb begin
        o_phase = '0;
        case (r_state)
            S_START: begin
                o_phase.scl_release = START_SCL[r_cnt];
                o_phase.sda_release = START_SDA[r_cnt];
                o_phase.last        = (r_cnt == COND_LAST_IDX);
            end
            S_STOP: begin
                o_phase.scl_release = STOP_SCL[r_cnt];
                o_phase.sda_release = STOP_SDA[r_cnt];
                o_phase.last        = (r_cnt == COND_LAST_IDX);
            end
            S_BITS: begin
                o_phase.scl_release = (r_cnt == BIT_LAST_SUB);
                // first phase of a bit still holds the previous level
                o_phase.sda_release = (r_cnt == 3'd0) ? r_sda_prev : r_shift[7];
            end
            S_ACK: begin
                o_phase.scl_release = (r_cnt == 3'd2);
                o_phase.sda_release = (r_cnt == 3'd0) ? r_sda_prev : 1'b1;
                if (r_cnt == ACK_LAST_IDX) begin
                    o_phase.sampled_ack = r_ack;
                    o_phase.last        = 1'b1;
                end
            end
            default: begin
                o_phase = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else if (w_accept) begin
            case (i_in_item.req_type)
                CMD_START: r_state <= S_START;
                CMD_WRITE: r_state <= S_BITS;
                CMD_STOP:  r_state <= S_STOP;
                default:   r_state <= S_IDLE;
            endcase
            r_cnt      <= 3'd0;
            r_bitn     <= 3'd0;
            r_shift    <= i_in_item.data_byte;
            r_sda_prev <= 1'b1;
            r_ack      <= i_in_item.ack_lines;
        end else if (i_advance) begin
            case (r_state)
                S_START, S_STOP: begin
                    if (r_cnt == COND_LAST_IDX) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_BITS: begin
                    if (r_cnt == BIT_LAST_SUB) begin
                        r_cnt      <= 3'd0;
                        r_sda_prev <= r_shift[7];
                        r_shift    <= {r_shift[6:0], 1'b0};
                        if (r_bitn == BYTE_LAST_BIT) begin
                            r_state <= S_ACK;
                        end else begin
                            r_bitn <= r_bitn + 3'd1;
                        end
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                S_ACK: begin
                    if (r_cnt == ACK_LAST_IDX) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + 3'd1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the multilane i2c byte writer
// Sends start, byte write and stop requests, some with unknown command
// codes, and builds the expected pin phases of each request as it is taken.
// Every phase that leaves the block is compared with the oldest expected
// one. Both sides idle and stall at random, and there is one long output
// hold-off and several drain pauses.
// ----------------------------------------------------------------------------
module tb_top;
    import i2cmbw_pkg::*;

    localparam int          LANES       = 9;
    localparam logic [1:0]  CMD_UNUSED  = 2'd3;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          RAND_ITEMS  = 320;
    localparam int          MAX_PRINTS  = 60;
    localparam logic [ACK_W-1:0] LANE_MASK =
        (LANES >= ACK_W) ? {ACK_W{1'b1}} : ACK_W'((1 << LANES) - 1);

    logic      i_clk      = 1'b0;
    logic      i_rst_n    = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in_item  = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out_item;

    t_out_item expected_phases[$];
    int        mismatch_count = 0;
    int        requests_sent  = 0;
    int        cycle_count    = 0;
    int        send_idle_pct  = 34;
    int        stall_pct      = 34;
    int        hold_request   = 0;
    int        hold_left      = 0;

    logic      seen_rst   = 1'b0;
    logic      seen_valid = 1'b0;
    logic      seen_stall = 1'b0;
    t_out_item seen_item  = '0;

    i2c_multilane_byte_writer_top #(
        .LANES(LANES)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_item (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // expected pin phases
    // ------------------------------------------------------------------------
    function automatic void push_phase(input logic scl, input logic sda,
                                       input logic [ACK_W-1:0] ack,
                                       input logic fin);
        t_out_item ph;
        ph.scl_release = scl;
        ph.sda_release = sda;
        ph.sampled_ack = ack;
        ph.last        = fin;
        expected_phases.push_back(ph);
    endfunction

    function automatic void predict_phases(input t_in_item req);
        logic       sda_lvl;
        logic       bit_lvl;
        logic [7:0] shreg;
        sda_lvl = 1'b1;
        shreg   = req.data_byte;
        case (req.req_type)
            CMD_START: begin
                // data falls while the clock is high
                push_phase(1'b1, 1'b1, '0, 1'b0);
                push_phase(1'b1, 1'b1, '0, 1'b0);
                push_phase(1'b1, 1'b1, '0, 1'b0);
                push_phase(1'b1, 1'b0, '0, 1'b0);
                push_phase(1'b0, 1'b0, '0, 1'b0);
                push_phase(1'b0, 1'b1, '0, 1'b1);
            end
            CMD_STOP: begin
                // data rises while the clock is high
                push_phase(1'b0, 1'b1, '0, 1'b0);
                push_phase(1'b0, 1'b0, '0, 1'b0);
                push_phase(1'b1, 1'b0, '0, 1'b0);
                push_phase(1'b1, 1'b0, '0, 1'b0);
                push_phase(1'b1, 1'b0, '0, 1'b0);
                push_phase(1'b1, 1'b1, '0, 1'b1);
            end
            CMD_WRITE: begin
                for (int i = 0; i < 8; i++) begin
                    bit_lvl = shreg[7];
                    push_phase(1'b0, sda_lvl, '0, 1'b0);
                    sda_lvl = bit_lvl;
                    push_phase(1'b0, sda_lvl, '0, 1'b0);
                    push_phase(1'b1, sda_lvl, '0, 1'b0);
                    shreg = {shreg[6:0], 1'b0};
                end
                // acknowledge slot, data released for the slaves
                push_phase(1'b0, sda_lvl, '0, 1'b0);
                push_phase(1'b0, 1'b1, '0, 1'b0);
                push_phase(1'b1, 1'b1, '0, 1'b0);
                push_phase(1'b0, 1'b1, req.ack_lines & LANE_MASK, 1'b1);
            end
            default: begin
                // unknown command is dropped without phases
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // phase checking
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTS)
            $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    endtask

    task automatic check_phase(input t_out_item got);
        t_out_item want;
        if (expected_phases.size() == 0) begin
            report_mismatch("phase with nothing expected", 32'(got), 32'd0);
            return;
        end
        want = expected_phases.pop_front();
        if (got.scl_release !== want.scl_release)
            report_mismatch("scl_release", 32'(got.scl_release), 32'(want.scl_release));
        if (got.sda_release !== want.sda_release)
            report_mismatch("sda_release", 32'(got.sda_release), 32'(want.sda_release));
        if (got.sampled_ack !== want.sampled_ack)
            report_mismatch("sampled_ack", 32'(got.sampled_ack), 32'(want.sampled_ack));
        if (got.last !== want.last)
            report_mismatch("last", 32'(got.last), 32'(want.last));
    endtask

    // outputs settle by the falling edge and hold until the next rising one
    always @(negedge i_clk) begin
        seen_rst   = i_rst_n;
        seen_valid = o_out_valid;
        seen_stall = i_out_stall;
        seen_item  = o_out_item;
    end

    always @(posedge i_clk) begin
        if (seen_rst && seen_valid === 1'b1 && !seen_stall)
            check_phase(seen_item);
    end

    // phase receiver: random stalls, plus a counted hold-off on request
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // request side
    // ------------------------------------------------------------------------
    task automatic send_request(input t_in_item req);
        logic stalled;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= req;
        do begin
            @(negedge i_clk);
            stalled = o_in_stall;
            @(posedge i_clk);
        end while (stalled !== 1'b0);
        predict_phases(req);
        requests_sent++;
    endtask

    task automatic send_cmd(input logic [1:0] cmd, input logic [7:0] data,
                            input logic [ACK_W-1:0] ack);
        t_in_item req;
        req.req_type  = cmd;
        req.data_byte = data;
        req.ack_lines = ack;
        send_request(req);
    endtask

    task automatic wait_all_phases();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_phases.size() != 0);
    endtask

    // well-formed transfer: start, a few bytes, stop
    task automatic send_transfer(input int max_bytes);
        int nbytes;
        nbytes = $urandom_range(1, max_bytes);
        send_cmd(CMD_START, 8'($urandom), ACK_W'($urandom));
        for (int i = 0; i < nbytes; i++)
            send_cmd(CMD_WRITE, 8'($urandom), ACK_W'($urandom));
        send_cmd(CMD_STOP, 8'($urandom), ACK_W'($urandom));
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        send_cmd(CMD_START, 8'h00, '0);
        send_cmd(CMD_WRITE, 8'h00, '0);
        send_cmd(CMD_WRITE, 8'hff, 9'h1ff);
        send_cmd(CMD_WRITE, 8'haa, 9'h155);
        send_cmd(CMD_WRITE, 8'h55, 9'h0aa);
        send_cmd(CMD_WRITE, 8'h80, 9'h100);
        send_cmd(CMD_WRITE, 8'h01, 9'h001);
        send_cmd(CMD_STOP, 8'h00, '0);
        // unused fields must not leak into start and stop
        send_cmd(CMD_START, 8'hff, 9'h1ff);
        send_cmd(CMD_STOP, 8'hff, 9'h1ff);
        // unknown command is taken and dropped
        send_cmd(CMD_UNUSED, 8'h00, '0);
        send_cmd(CMD_UNUSED, 8'hff, 9'h1ff);
        send_cmd(CMD_START, 8'h3c, 9'h0f0);
        send_cmd(CMD_UNUSED, 8'h5a, 9'h0a5);
        send_cmd(CMD_WRITE, 8'h7f, 9'h0ff);
        send_cmd(CMD_STOP, 8'hc3, 9'h10f);
        wait_all_phases();
    endtask

    task automatic test_random_traffic(input int target);
        while (requests_sent < target) begin
            if ($urandom_range(0, 99) < 85) begin
                send_transfer(4);
            end else begin
                // noise: stray or unknown commands
                send_cmd(2'($urandom_range(0, 3)), 8'($urandom), ACK_W'($urandom));
            end
            if ($urandom_range(0, 99) < 10)
                wait_all_phases();
        end
        wait_all_phases();
    endtask

    task automatic test_back_to_back(input int target);
        send_idle_pct = 0;
        stall_pct     = 0;
        while (requests_sent < target)
            send_transfer(3);
        wait_all_phases();
        send_idle_pct = 34;
        stall_pct     = 34;
    endtask

    task automatic test_output_hold();
        send_idle_pct = 0;
        hold_request  = 400;
        for (int i = 0; i < 3; i++)
            send_transfer(2);
        send_cmd(CMD_UNUSED, 8'($urandom), ACK_W'($urandom));
        wait_all_phases();
        send_idle_pct = 34;
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random_traffic(requests_sent + RAND_ITEMS * 5 / 8);
        test_back_to_back(requests_sent + RAND_ITEMS / 8);
        test_output_hold();
        test_random_traffic(requests_sent + RAND_ITEMS / 4);

        repeat (40) @(posedge i_clk);
        if (expected_phases.size() != 0)
            report_mismatch("phases never sent", 32'(expected_phases.size()), 32'd0);
        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/i2cmbw_pkg.sv
sv/i2cmbw_sequencer.sv
sv/i2c_multilane_byte_writer_top.sv
dv/tb_top.sv
